FILE: hdl/swqe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shell word quote encoder.
// No dependencies; imported by every module of the block.
package swqe_pkg;

   // Most characters one input word can give: open quote plus the
   // four-character form of a single quote plus close quote.
   localparam int MAX_OUT     = 6;
   localparam int CNT_W       = $clog2(MAX_OUT + 1);
   localparam int IDX_W       = $clog2(MAX_OUT);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [1:0] {
      STYLE_BACKSLASH = 2'd0,
      STYLE_DOUBLE    = 2'd1,
      STYLE_SINGLE    = 2'd2
   } style_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUOTE_STYLE = 3'd0,
      CSR_MULTI_MATCH = 3'd1,
      CSR_SHELL_MODE  = 3'd2,
      CSR_ESCAPE_GLOB = 3'd3,
      CSR_GUARD_TILDE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0] quote_style;
      logic       multi_match;
      logic       shell_mode;
      logic       escape_glob;
      logic       guard_tilde;
   } cfg_type;

   // One expanded input word: its output characters in order.
   typedef struct packed {
      logic                    last;
      logic [CNT_W-1:0]        count;
      logic [MAX_OUT-1:0][7:0] chars;
   } rec_type;

   // Queue read side towards the emitter.
   typedef struct packed {
      logic    valid;
      rec_type rec;
   } qhead_type;

endpackage

FILE: hdl/swqe_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, tracks word framing and expands each
// word into its quoted characters. Depends on swqe_pkg.
module swqe_front
   import swqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic [1:0] req_tuser,
   input  logic       q_ready,
   output logic       push,
   output rec_type    push_rec
);

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_LBRK   = 8'h5b;
   localparam logic [7:0] CH_BSL    = 8'h5c;
   localparam logic [7:0] CH_RBRK   = 8'h5d;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_PIPE   = 8'h7c;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_TILDE  = 8'h7e;

   logic word_open_ff, word_open_in;
   logic at_start_ff, at_start_in;

   logic       accept;
   logic       first, last, none, start, leading;
   logic       is_break, is_glob, is_shell, need_esc, guard;
   logic [7:0] c;
   logic [1:0] style;
   logic [CNT_W-1:0] n;

   assign c       = req_tdata;
   assign first   = req_tuser[0];
   assign last    = req_tlast;
   assign none    = req_tuser[1] || (c == 8'h00);
   assign start   = first || !word_open_ff;
   assign leading = start || at_start_ff;
   assign style   = (cfg.quote_style == STYLE_DOUBLE || cfg.quote_style == STYLE_SINGLE)
                    ? cfg.quote_style : STYLE_BACKSLASH;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   // classify the character for backslash style
   always_comb begin
      is_break = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_DQUOTE) ||
                 (c == CH_SQUOTE) || (c == CH_PIPE) || (c == CH_BANG) || (c == CH_AMP) ||
                 (c == CH_SEMI) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_DOLLAR) ||
                 (c == CH_PCT) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ);
      is_shell = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_CARET) || (c == CH_BTICK);
      is_glob  = (c == CH_STAR) || (c == CH_LBRK) || (c == CH_QMARK) || (c == CH_RBRK);
      need_esc = (c == CH_BSL) || is_break || (cfg.shell_mode && is_shell) ||
                 ((cfg.shell_mode || cfg.escape_glob) && is_glob) ||
                 (cfg.shell_mode && leading && (c == CH_HASH));
      guard    = (c == CH_TILDE) && leading && cfg.guard_tilde;
   end

   // expand the word into its output characters
   always_comb begin
      push_rec       = '0;
      push_rec.last  = last;
      n              = '0;
      if (start) begin
         if (style == STYLE_DOUBLE) begin
            push_rec.chars[n[IDX_W-1:0]] = CH_DQUOTE;
            n = n + 1'b1;
         end else if (style == STYLE_SINGLE) begin
            push_rec.chars[n[IDX_W-1:0]] = CH_SQUOTE;
            n = n + 1'b1;
         end
      end
      if (!none) begin
         unique case (style)
            STYLE_DOUBLE: begin
               if ((c == CH_DQUOTE) || (c == CH_BSL) ||
                   (cfg.shell_mode && ((c == CH_DOLLAR) || (c == CH_BTICK)))) begin
                  push_rec.chars[n[IDX_W-1:0]] = CH_BSL;
                  n = n + 1'b1;
               end
               push_rec.chars[n[IDX_W-1:0]] = c;
               n = n + 1'b1;
            end
            STYLE_SINGLE: begin
               push_rec.chars[n[IDX_W-1:0]] = c;
               n = n + 1'b1;
               if (c == CH_SQUOTE) begin
                  push_rec.chars[n[IDX_W-1:0]] = CH_BSL;
                  n = n + 1'b1;
                  push_rec.chars[n[IDX_W-1:0]] = CH_SQUOTE;
                  n = n + 1'b1;
                  push_rec.chars[n[IDX_W-1:0]] = CH_SQUOTE;
                  n = n + 1'b1;
               end
            end
            default: begin
               if (guard) begin
                  push_rec.chars[n[IDX_W-1:0]] = CH_DOT;
                  n = n + 1'b1;
                  push_rec.chars[n[IDX_W-1:0]] = CH_SLASH;
                  n = n + 1'b1;
               end else if (need_esc) begin
                  push_rec.chars[n[IDX_W-1:0]] = CH_BSL;
                  n = n + 1'b1;
               end
               push_rec.chars[n[IDX_W-1:0]] = c;
               n = n + 1'b1;
            end
         endcase
      end
      if (last && !cfg.multi_match) begin
         if (style == STYLE_DOUBLE) begin
            push_rec.chars[n[IDX_W-1:0]] = CH_DQUOTE;
            n = n + 1'b1;
         end else if (style == STYLE_SINGLE) begin
            push_rec.chars[n[IDX_W-1:0]] = CH_SQUOTE;
            n = n + 1'b1;
         end
      end
      push_rec.count = n;
   end

   // words that expand to nothing only move the framing state
   assign push = accept && (n != '0);

   always_comb begin
      word_open_in = word_open_ff;
      at_start_in  = at_start_ff;
      if (accept) begin
         word_open_in = !last;
         at_start_in  = none ? leading : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_open_ff <= 1'b0;
         at_start_ff  <= 1'b0;
      end else begin
         word_open_ff <= word_open_in;
         at_start_ff  <= at_start_in;
      end
   end

endmodule

FILE: hdl/swqe_queue.sv
`timescale 1ns / 1ps
// Short queue of expanded words between front and back end.
// Depends on swqe_pkg.
module swqe_queue
   import swqe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  rec_type   push_rec,
   output logic      q_ready,
   input  logic      pop,
   output qhead_type head
);

   rec_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign q_ready    = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.rec   = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/swqe_back.sv
`timescale 1ns / 1ps
// Back end: takes expanded words from the queue and emits their
// characters one per cycle while rsp_tready is high. Depends on swqe_pkg.
module swqe_back
   import swqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qhead_type  head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   rec_type          cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             at_end, done;

   assign at_end = (CNT_W'(idx_ff) == cur_ff.count - 1'b1);
   assign done   = valid_ff && rsp_tready && at_end;
   assign pop    = head.valid && (!valid_ff || done);

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (pop) begin
         cur_in   = head.rec;
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_tready) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cur_ff.chars[idx_ff];
   assign rsp_tuser  = at_end;
   assign rsp_tlast  = at_end && cur_ff.last;

endmodule

FILE: hdl/shell_word_quote_encoder.sv
`timescale 1ns / 1ps
// Shell word quote encoder, top level: register file, front end, queue and
// back end. Depends on swqe_pkg, swqe_front, swqe_queue and swqe_back.
//
// Feed the characters of a word one word per beat on the req_ channel and
// take the quoted form from the rsp_ channel, one character per beat. The
// front end takes a new input word in every cycle while the four-entry
// queue has room, expanding it at once into its zero to six output
// characters; the back end emits one character per cycle from the head of
// the queue while rsp_tready is high, so the sustained rate is one output
// character per clock, set by that emitter, when the receiver does not
// stall. A word is written into a queue slot and then loaded into the back
// end's current-word register before its first character is on rsp_. Registers
// are sampled when a word is taken, so write them only while the block is
// idle; csr_ready is always high.
module shell_word_quote_encoder
   import swqe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_in
   input  logic                  req_tlast,   // word_last
   input  logic [1:0]            req_tuser,   // [0] word_first, [1] no_char
   // quoted characters
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] char_out
   output logic                  rsp_tlast,   // word_end
   output logic                  rsp_tuser    // [0] run_end
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_ready, push, pop;
   rec_type   push_rec;
   qhead_type head;

   assign csr_ready = 1'b1;

   // register writes; an index beyond the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_QUOTE_STYLE: cfg_in.quote_style = csr_data[1:0];
            CSR_MULTI_MATCH: cfg_in.multi_match = csr_data[0];
            CSR_SHELL_MODE:  cfg_in.shell_mode  = csr_data[0];
            CSR_ESCAPE_GLOB: cfg_in.escape_glob = csr_data[0];
            CSR_GUARD_TILDE: cfg_in.guard_tilde = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and expand each word as it arrives
   swqe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .push       (push),
      .push_rec   (push_rec)
   );

   // hold expanded words until the emitter is free
   swqe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .q_ready  (q_ready),
      .pop      (pop),
      .head     (head)
   );

   // advance through each expanded word, one character a beat
   swqe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // a quoted character is never zero
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 8'h00))
      else $error("zero character on output");

   // a word end is always the end of its run
   a_word_end_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("word end without run end");

   // nothing is shown in the cycle after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid straight after reset");
`endif

endmodule

FILE: tb/sv/shell_word_quote_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of shell_word_quote_encoder: a stimulus table, then random
// words under four idling patterns, checked against an in-bench quoting predictor.
// Depends on swqe_pkg and the RTL of the block.
module shell_word_quote_encoder_tb;
   import swqe_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES    = 10;    // covers a word that gives no characters
   localparam int WORDS_PER_CONFIG = 28;
   localparam int FIRST_SPARE_CSR  = CSR_GUARD_TILDE + 1;
   localparam logic [7:0] CH_BACKTICK = 8'h60;

   // one quoted character as it should leave the rsp_ channel
   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       word_end;
   } quoted_char_type;

   // one row of the stimulus table; typed_n < 0 leaves the check to the predictor
   typedef struct {
      cfg_type           cfg;
      logic [7:0]        ch;
      logic              first;
      logic              last;
      logic              none;
      int                typed_n;
      logic [0:5][7:0]   typed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] char_in
   logic                  req_tlast = 1'b0; // word_last
   logic [1:0]            req_tuser = '0;   // [0] word_first, [1] no_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [7:0] char_out
   logic                  rsp_tlast;        // word_end
   logic                  rsp_tuser;        // [0] run_end

   // typed-in expectation travelling alongside the word on the req_ channel
   int                    drv_typed_n = -1;
   logic [0:5][7:0]       drv_typed = '0;

   // bench copy of the registers and of the word framing state
   cfg_type               cfg_copy = '0;
   logic                  word_open_q = 1'b0;
   logic                  at_start_q = 1'b0;

   quoted_char_type       quoted_chars_due[$];
   stim_row_type          stim_rows[$];

   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    idle_cycles = 0;
   int                    fail_count = 0;
   int                    words_sent = 0;
   int                    chars_checked = 0;
   int                    configs_used = 0;

   string                 specials = " \t\n\"'|!&;()$%<>=\\{}^*[?]#~";

   shell_word_quote_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // receiver: stall at random, one decision per edge
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic is_word_break(input logic [7:0] c);
      case (c)
         " ", "\t", "\n", "\"", "'", "|", "!", "&", ";", "(", ")",
         "$", "%", "<", ">", "=": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // backslash style: does this character need a backslash in front of it
   function automatic logic needs_backslash(input cfg_type cfg, input logic [7:0] c,
                                            input logic leading);
      if (c == "\\" || is_word_break(c))
         return 1'b1;
      case (c)
         "{", "}", "^", CH_BACKTICK: return cfg.shell_mode;
         "*", "[", "?", "]":         return cfg.shell_mode | cfg.escape_glob;
         "#":                        return cfg.shell_mode & leading;
         default:                    return 1'b0;
      endcase
   endfunction

   // Expand one input word into its quoted characters; advances the framing state.
   function automatic int quote_word(input cfg_type cfg, input logic [7:0] c,
                                     input logic first, input logic last,
                                     input logic no_char, output logic [0:5][7:0] seq);
      int        n;
      logic      none;
      style_type style;
      n = 0;
      seq = '0;
      none = no_char || (c == 8'h00);
      // the unused style code falls back to backslash escaping
      if (cfg.quote_style == STYLE_DOUBLE)
         style = STYLE_DOUBLE;
      else if (cfg.quote_style == STYLE_SINGLE)
         style = STYLE_SINGLE;
      else
         style = STYLE_BACKSLASH;

      // open a word on a first mark, or implicitly when none is open
      if (first || !word_open_q) begin
         word_open_q = 1'b1;
         at_start_q = 1'b1;
         if (style == STYLE_DOUBLE) begin
            seq[n] = "\"";
            n++;
         end else if (style == STYLE_SINGLE) begin
            seq[n] = "'";
            n++;
         end
      end

      if (!none) begin
         if (style == STYLE_DOUBLE) begin
            if (c == "\"" || c == "\\" ||
                (cfg.shell_mode && (c == "$" || c == CH_BACKTICK))) begin
               seq[n] = "\\";
               n++;
            end
            seq[n] = c;
            n++;
         end else if (style == STYLE_SINGLE) begin
            seq[n] = c;
            n++;
            // close, escaped quote, reopen
            if (c == "'") begin
               seq[n] = "\\";
               seq[n+1] = "'";
               seq[n+2] = "'";
               n += 3;
            end
         end else begin
            if (c == "~" && at_start_q && cfg.guard_tilde) begin
               seq[n] = ".";
               seq[n+1] = "/";
               n += 2;
            end else if (needs_backslash(cfg, c, at_start_q)) begin
               seq[n] = "\\";
               n++;
            end
            seq[n] = c;
            n++;
         end
         at_start_q = 1'b0;
      end

      if (last) begin
         if (style == STYLE_DOUBLE && !cfg.multi_match) begin
            seq[n] = "\"";
            n++;
         end else if (style == STYLE_SINGLE && !cfg.multi_match) begin
            seq[n] = "'";
            n++;
         end
         word_open_q = 1'b0;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      logic [0:5][7:0] seq;
      int              n;
      quoted_char_type exp_char;
      if (!reset) begin
         // compare each accepted character with the oldest one due
         if (rsp_tvalid && rsp_tready) begin
            if (quoted_chars_due.size() == 0) begin
               $error("unexpected character %h with nothing due", rsp_tdata);
               fail_count++;
            end else begin
               exp_char = quoted_chars_due.pop_front();
               if (rsp_tdata !== exp_char.ch) begin
                  $error("char_out: expected %h, got %h", exp_char.ch, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== exp_char.run_end) begin
                  $error("run_end: expected %b, got %b", exp_char.run_end, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== exp_char.word_end) begin
                  $error("word_end: expected %b, got %b", exp_char.word_end, rsp_tlast);
                  fail_count++;
               end
            end
            chars_checked++;
         end

         // predict every accepted word; a typed-in row overrides the predictor
         if (req_tvalid && req_tready) begin
            n = quote_word(cfg_copy, req_tdata, req_tuser[0], req_tlast, req_tuser[1], seq);
            if (drv_typed_n >= 0) begin
               n = drv_typed_n;
               seq = drv_typed;
            end
            for (int k = 0; k < n; k++) begin
               exp_char.ch = seq[k];
               exp_char.run_end = (k == n - 1);
               exp_char.word_end = (k == n - 1) && req_tlast;
               quoted_chars_due.push_back(exp_char);
            end
            words_sent++;
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------- drivers

   function automatic cfg_type mk_cfg(input logic [1:0] style, input logic mm,
                                      input logic sh, input logic eg, input logic gt);
      cfg_type cfg;
      cfg.quote_style = style;
      cfg.multi_match = mm;
      cfg.shell_mode = sh;
      cfg.escape_glob = eg;
      cfg.guard_tilde = gt;
      return cfg;
   endfunction

   function automatic void add_row(input cfg_type cfg, input logic [7:0] ch,
                                   input logic first, input logic last, input logic none,
                                   input int typed_n = -1,
                                   input logic [0:5][7:0] typed = '0);
      stim_row_type row;
      row.cfg = cfg;
      row.ch = ch;
      row.first = first;
      row.last = last;
      row.none = none;
      row.typed_n = typed_n;
      row.typed = typed;
      stim_rows.push_back(row);
   endfunction

   // Hold csr_valid high; the caller lowers it after the last write of a batch.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_QUOTE_STYLE: cfg_copy.quote_style = data[1:0];
         CSR_MULTI_MATCH: cfg_copy.multi_match = data[0];
         CSR_SHELL_MODE:  cfg_copy.shell_mode = data[0];
         CSR_ESCAPE_GLOB: cfg_copy.escape_glob = data[0];
         CSR_GUARD_TILDE: cfg_copy.guard_tilde = data[0];
         default: ;
      endcase
   endtask

   // Write every register; with junk set, fill the unused data bits and poke a spare index.
   task automatic apply_cfg(input cfg_type cfg, input logic junk);
      logic [7:0] fill;
      fill = junk ? 8'($urandom) : 8'h00;
      write_reg(CSR_QUOTE_STYLE, {fill[7:2], cfg.quote_style});
      write_reg(CSR_MULTI_MATCH, {fill[7:1], cfg.multi_match});
      write_reg(CSR_SHELL_MODE,  {fill[6:0], cfg.shell_mode});
      write_reg(CSR_ESCAPE_GLOB, {fill[5:0], fill[7], cfg.escape_glob});
      write_reg(CSR_GUARD_TILDE, {fill[4:0], fill[7:6], cfg.guard_tilde});
      if (junk)
         write_reg(CSR_IDX_W'($urandom_range(FIRST_SPARE_CSR, (1 << CSR_IDX_W) - 1)),
                   8'($urandom));
      csr_valid <= 1'b0;
      configs_used++;
   endtask

   // Drop valid, let every due character arrive, then let the pipeline settle.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (quoted_chars_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one word, idling first at random; returns at the accepting edge.
   task automatic send_word(input logic [7:0] ch, input logic first, input logic last,
                            input logic none, input int typed_n = -1,
                            input logic [0:5][7:0] typed = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      req_tuser <= {none, first};
      drv_typed_n <= typed_n;
      drv_typed <= typed;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [7:0] pick_char;
      int r;
      int i;
      r = $urandom_range(99);
      if (r < 45) begin
         i = $urandom_range(specials.len());
         return (i == specials.len()) ? CH_BACKTICK : 8'(specials[i]);
      end else if (r < 75) begin
         return 8'($urandom_range(8'h7E, 8'h21));
      end
      return 8'($urandom);
   endfunction

   // A well-formed word of random content, with some framing noise mixed in.
   task automatic send_random_word(inout int budget);
      int         len;
      logic [7:0] ch;
      logic       first;
      logic       last;
      logic       none;
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
      if (len == 0) begin
         // empty word: a single item without a character
         send_word(8'($urandom), 1'b1, 1'b1, 1'b1);
         budget--;
      end else begin
         for (int i = 0; i < len; i++) begin
            ch = pick_char();
            first = (i == 0);
            last = (i == len - 1);
            none = 1'b0;
            if ($urandom_range(99) < 12) begin
               case ($urandom_range(3))
                  0: first = ~first;
                  1: last = ~last;
                  2: none = 1'b1;
                  default: ch = 8'h00;
               endcase
            end
            send_word(ch, first, last, none);
            budget--;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main
      cfg_type      cfg;
      stim_row_type row;
      int           budget;

      // after reset: backslash style, every flag clear
      cfg = mk_cfg(STYLE_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(cfg, "a", 1, 1, 0, 1, {"a", 40'h0});
      add_row(cfg, " ", 1, 1, 0, 2, {"\\", " ", 32'h0});
      add_row(cfg, 8'hFF, 1, 1, 0, 1, {8'hFF, 40'h0});
      add_row(cfg, "q", 1, 1, 1, 0);                    // empty word, nothing out
      add_row(cfg, 8'h00, 1, 1, 0, 0);                  // character zero acts as none
      add_row(cfg, "*", 1, 1, 0, 1, {"*", 40'h0});
      add_row(cfg, "~", 1, 1, 0, 1, {"~", 40'h0});
      // shell mode with tilde guard: leading hash, tilde after an empty item
      cfg = mk_cfg(STYLE_BACKSLASH, 1'b0, 1'b1, 1'b0, 1'b1);
      add_row(cfg, "#", 1, 0, 0);
      add_row(cfg, "#", 0, 1, 0);
      add_row(cfg, 8'h00, 1, 0, 1);
      add_row(cfg, "~", 0, 1, 0);
      add_row(cfg, "{", 1, 1, 0);
      cfg = mk_cfg(STYLE_BACKSLASH, 1'b0, 1'b0, 1'b1, 1'b0);
      add_row(cfg, "[", 1, 1, 0);
      // unused style code
      cfg = mk_cfg(2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(cfg, "$", 1, 1, 0);
      // double quotes in shell mode; a first mark inside a word abandons it
      cfg = mk_cfg(STYLE_DOUBLE, 1'b0, 1'b1, 1'b0, 1'b0);
      add_row(cfg, "\"", 1, 1, 0, 4, {"\"", "\\", "\"", "\"", 16'h0});
      add_row(cfg, CH_BACKTICK, 1, 0, 0);
      add_row(cfg, "x", 1, 1, 0);
      add_row(cfg, 8'h00, 1, 1, 1);
      // single quotes: a lone quote gives the longest expansion
      cfg = mk_cfg(STYLE_SINGLE, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(cfg, "'", 1, 1, 0, 6, {"'", "'", "\\", "'", "'", "'"});
      add_row(cfg, "b", 0, 1, 0);                       // no first mark, word opens anyway
      cfg = mk_cfg(STYLE_SINGLE, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(cfg, "c", 1, 1, 0);
      cfg = mk_cfg(STYLE_DOUBLE, 1'b1, 1'b1, 1'b1, 1'b1);
      add_row(cfg, 8'h80, 1, 1, 0);
      add_row(cfg, 8'h00, 1, 1, 1);
      add_row(cfg, 8'h00, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.cfg != cfg_copy) begin
            drain();
            apply_cfg(row.cfg, 1'b0);
         end
         send_word(row.ch, row.first, row.last, row.none, row.typed_n, row.typed);
      end

      // random words: two settings per idling pattern, the second of the first
      // pattern in single-quote style with every flag set
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         for (int s = 0; s < 2; s++) begin
            if (phase == 0 && s == 1)
               cfg = mk_cfg(STYLE_SINGLE, 1'b1, 1'b1, 1'b1, 1'b1);
            else
               cfg = mk_cfg(2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                            1'($urandom), 1'($urandom));
            drain();
            apply_cfg(cfg, 1'b1);
            budget = WORDS_PER_CONFIG;
            while (budget > 0)
               send_random_word(budget);
         end
      end

      drain();
      $display("covered %0d input words and %0d quoted characters under %0d register settings",
               words_sent, chars_checked, configs_used + 1);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/swqe_pkg.sv
hdl/swqe_front.sv
hdl/swqe_queue.sv
hdl/swqe_back.sv
hdl/shell_word_quote_encoder.sv
tb/sv/shell_word_quote_encoder_tb.sv
